[sv/grid_cell_hash_index_top_defines.svh]
// Assertion macros for the grid cell hash index.
// Each expects clk and arst_n in scope.
`ifndef GRID_CELL_HASH_INDEX_TOP_DEFINES_SVH
`define GRID_CELL_HASH_INDEX_TOP_DEFINES_SVH

// same-cycle implication
`define GCHI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gchi: check failed");

// next-cycle implication
`define GCHI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gchi: check failed");

`endif

[sv/gchi_pkg.sv]
// ----------------------------------------------------------------------------
// gchi_pkg
// Codes, FSM states and the controller/datapath interface of the index.
// ----------------------------------------------------------------------------
package gchi_pkg;

	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_QUERY  = 3'd2;
	localparam logic [2:0] REQ_HAS    = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL = 3'd2;
	localparam logic [2:0] ST_CELL_FULL  = 3'd3;
	localparam logic [2:0] ST_INVALID    = 3'd4;

	localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
	// prime = 2^40 + 0x1b3
	localparam int          FNV_SHIFT    = 40;
	localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;

	localparam logic [3:0] MAX_OUT = 4'd8;
	localparam logic [31:0] INV_RESET = 32'hffff_ffff;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_PRB_RD,
		S_PRB_CHK,
		S_DISPATCH,
		S_ADD_WR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MOVE_RD,
		S_MOVE_WR,
		S_QRY_RD,
		S_QRY_OUT,
		S_CLEAR,
		S_EMIT_OK
	} state_t;

	typedef struct packed {
		logic       load;
		logic       hash_step;
		logic       mod_step;
		logic       prb_rd;
		logic       prb_next;
		logic       claim;
		logic       take_cnt;
		logic       drop_cnt;
		logic       add_wr;
		logic       scan_rd;
		logic       scan_next;
		logic       move_rd;
		logic       move_wr;
		logic       qry_rd;
		logic       clear_all;
		logic       emit;
		logic       emit_ent;
		logic [2:0] code;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       ent_inv;
		logic       hash_last;
		logic       mod_last;
		logic       slot_claimed;
		logic       slot_match;
		logic       prb_last;
		logic       found;
		logic       cnt_full;
		logic       cnt_zero;
		logic       scan_hit;
		logic       scan_last;
		logic       qry_last;
		logic       out_busy;
	} sts_t;

endpackage

[sv/gchi_ram.sv]
// ----------------------------------------------------------------------------
// gchi_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gchi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/gchi_ctrl.sv]
// ----------------------------------------------------------------------------
// gchi_ctrl
// Request sequencer: hash, probe, then per-type update and result words.
// ----------------------------------------------------------------------------
module gchi_ctrl import gchi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] req_type,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   make;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		make     = (sts.req_type == REQ_ADD) && !sts.ent_inv;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (req_type == REQ_CLEAR) begin
						state_d = S_CLEAR;
					end else if (req_type < REQ_CLEAR) begin
						state_d = S_HASH;
					end
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) state_d = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_d = S_PRB_RD;
			end
			S_PRB_RD: begin
				cmd.prb_rd = 1'b1;
				state_d    = S_PRB_CHK;
			end
			S_PRB_CHK: begin
				priority if (!sts.slot_claimed) begin
					cmd.claim    = make;
					cmd.drop_cnt = !make;
					state_d      = S_DISPATCH;
				end else if (sts.slot_match) begin
					cmd.take_cnt = 1'b1;
					state_d      = S_DISPATCH;
				end else if (sts.prb_last) begin
					cmd.drop_cnt = 1'b1;
					state_d      = S_DISPATCH;
				end else begin
					cmd.prb_next = 1'b1;
					state_d      = S_PRB_RD;
				end
			end
			S_DISPATCH: begin
				priority case (sts.req_type)
					REQ_ADD: begin
						priority if (sts.ent_inv) cmd.code = ST_INVALID;
						else if (!sts.found) cmd.code = ST_TABLE_FULL;
						else if (sts.cnt_full) cmd.code = ST_CELL_FULL;
						else cmd.code = ST_OK;
						if (cmd.code == ST_OK) begin
							state_d = S_ADD_WR;
						end else if (!sts.out_busy) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					end
					REQ_REMOVE, REQ_HAS: begin
						priority if (sts.ent_inv) cmd.code = ST_INVALID;
						else if (!sts.found || sts.cnt_zero) cmd.code = ST_NOT_FOUND;
						else cmd.code = ST_OK;
						if (cmd.code == ST_OK) begin
							state_d = S_SCAN_RD;
						end else if (!sts.out_busy) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					end
					REQ_QUERY: begin
						cmd.code = ST_NOT_FOUND;
						if (!sts.cnt_zero) begin
							state_d = S_QRY_RD;
						end else if (!sts.out_busy) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = S_EMIT_OK;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				cmd.code = ST_NOT_FOUND;
				priority if (sts.scan_hit) begin
					state_d = (sts.req_type == REQ_REMOVE) ? S_MOVE_RD : S_EMIT_OK;
				end else if (sts.scan_last) begin
					if (!sts.out_busy) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_MOVE_RD: begin
				cmd.move_rd = 1'b1;
				state_d     = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				cmd.move_wr = 1'b1;
				state_d     = S_EMIT_OK;
			end
			S_QRY_RD: begin
				cmd.qry_rd = 1'b1;
				state_d    = S_QRY_OUT;
			end
			S_QRY_OUT: begin
				cmd.code = ST_OK;
				if (!sts.out_busy) begin
					cmd.emit     = 1'b1;
					cmd.emit_ent = 1'b1;
					if (sts.qry_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.scan_next = 1'b1;
						state_d       = S_QRY_RD;
					end
				end
			end
			S_CLEAR: begin
				cmd.clear_all = 1'b1;
				state_d       = S_EMIT_OK;
			end
			S_EMIT_OK: begin
				cmd.code = ST_OK;
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[sv/gchi_dp.sv]
// ----------------------------------------------------------------------------
// gchi_dp
// Datapath: FNV-1a hash, reciprocal-multiply slot index, slot and entity
// stores, counters and the output register.
// ----------------------------------------------------------------------------
module gchi_dp import gchi_pkg::*; #(
	parameter int TABLE_SLOTS = 256,
	parameter int PER_CELL    = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [31:0]        inv_ent,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] cell_x,
	input  logic signed [31:0] cell_y,
	input  logic [31:0]        ent_id,
	input  logic [3:0]         result_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [31:0]        found_entity,
	output logic [3:0]         cell_count,
	output logic [11:0]        total_count,
	output logic               last
);

	localparam int SW  = $clog2(TABLE_SLOTS);
	localparam int CW  = $clog2(PER_CELL + 1);
	localparam int EW  = $clog2(TABLE_SLOTS * PER_CELL);
	localparam int TW  = $clog2(TABLE_SLOTS * PER_CELL + 1);
	localparam int SLW = 64 + CW;
	localparam int RS  = 32 + SW;
	localparam logic [SW:0]   TS_W    = (SW + 1)'(TABLE_SLOTS);
	localparam logic [31:0]   TS_32   = 32'(TABLE_SLOTS);
	localparam logic [32:0]   RECIP   = 33'((64'd1 << RS) / 64'(TABLE_SLOTS));
	localparam logic [SW-1:0] POS_MAX = SW'(TABLE_SLOTS - 1);
	localparam logic [EW-1:0] PC_E    = EW'(PER_CELL);
	localparam logic [CW-1:0] PC_C    = CW'(PER_CELL);

	logic [2:0]        type_q;
	logic [31:0]       x_q, y_q, ent_q;
	logic [3:0]        lim_q;
	logic [63:0]       h_q;
	logic [4:0]        cnt_q;
	logic [64:0]       prod_q;
	logic [SW:0]       rem_q;
	logic [SW-1:0]     pos_q, n_q;
	logic [CW-1:0]     ccnt_q, i_q;
	logic [TW-1:0]     total_q;
	logic              found_q;
	logic [TABLE_SLOTS-1:0] claimed_q;

	logic [63:0]   key, hx, h_n;
	logic [31:0]   fold;
	logic [64:0]   prod_n;
	logic [31:0]   quo, rem_full;
	logic [SW-1:0] rem_fix;
	logic [SW-1:0] pos_n;
	logic [3:0]    lim_in;
	logic [7:0]    lim_eff;

	logic           slot_we, ent_we, ent_re;
	logic [CW-1:0]  slot_wcnt;
	logic [SLW-1:0] slot_rd;
	logic [EW-1:0]  base, ent_raddr, ent_waddr;
	logic [31:0]    ent_wdata, ent_rd;

	// hash and remainder
	assign key   = {x_q, y_q};
	assign hx    = h_q ^ {56'd0, key[{cnt_q[2:0], 3'b000} +: 8]};
	assign h_n   = (hx << FNV_SHIFT) + hx * FNV_PRIME_LO;
	assign fold  = h_q[31:0] ^ h_q[63:32];
	// quotient estimate is exact or one low, so one subtract corrects it
	assign prod_n   = 65'(fold) * 65'(RECIP);
	assign quo      = 32'(prod_q >> RS);
	assign rem_full = fold - quo * TS_32;
	assign rem_fix  = (rem_q >= TS_W) ? SW'(rem_q - TS_W) : rem_q[SW-1:0];
	assign pos_n = (pos_q == POS_MAX) ? '0 : pos_q + SW'(1);

	always_comb begin
		priority if (result_limit == 4'd0) lim_in = 4'd1;
		else if (result_limit > MAX_OUT) lim_in = MAX_OUT;
		else lim_in = result_limit;
	end

	assign lim_eff = (8'(lim_q) > 8'(ccnt_q)) ? 8'(ccnt_q) : 8'(lim_q);

	// stores
	assign slot_we = cmd.claim | cmd.add_wr | cmd.move_wr;
	always_comb begin
		priority if (cmd.claim) slot_wcnt = '0;
		else if (cmd.add_wr) slot_wcnt = ccnt_q + CW'(1);
		else slot_wcnt = ccnt_q - CW'(1);
	end

	gchi_ram #(.WIDTH(SLW), .DEPTH(TABLE_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (pos_q),
		.wdata ({x_q, y_q, slot_wcnt}),
		.re    (cmd.prb_rd),
		.raddr (pos_q),
		.rdata (slot_rd)
	);

	assign base      = EW'(pos_q) * PC_E;
	assign ent_re    = cmd.scan_rd | cmd.qry_rd | cmd.move_rd;
	assign ent_raddr = base + EW'(cmd.move_rd ? ccnt_q - CW'(1) : i_q);
	assign ent_we    = cmd.add_wr | cmd.move_wr;
	assign ent_waddr = base + EW'(cmd.add_wr ? ccnt_q : i_q);
	assign ent_wdata = cmd.add_wr ? ent_q : ent_rd;

	gchi_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS * PER_CELL)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rd)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			x_q    <= cell_x;
			y_q    <= cell_y;
			ent_q  <= ent_id;
			lim_q  <= lim_in;
			h_q    <= FNV_BASIS;
			cnt_q  <= '0;
			rem_q  <= '0;
			i_q    <= '0;
		end
		if (cmd.hash_step) begin
			h_q   <= h_n;
			cnt_q <= (cnt_q[2:0] == 3'd7) ? 5'd0 : cnt_q + 5'd1;
		end
		if (cmd.mod_step) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd0) prod_q <= prod_n;
			if (cnt_q == 5'd1) rem_q <= rem_full[SW:0];
			if (cnt_q == 5'd2) begin
				pos_q <= rem_fix;
				n_q   <= '0;
			end
		end
		if (cmd.prb_next) begin
			pos_q <= pos_n;
			n_q   <= n_q + SW'(1);
		end
		if (cmd.scan_next) i_q <= i_q + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= '0;
			total_q   <= '0;
			ccnt_q    <= '0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load) found_q <= 1'b0;
			if (cmd.claim) begin
				claimed_q[pos_q] <= 1'b1;
				ccnt_q           <= '0;
				found_q          <= 1'b1;
			end
			if (cmd.take_cnt) begin
				ccnt_q  <= slot_rd[CW-1:0];
				found_q <= 1'b1;
			end
			if (cmd.drop_cnt) ccnt_q <= '0;
			if (cmd.add_wr) begin
				ccnt_q  <= ccnt_q + CW'(1);
				total_q <= total_q + TW'(1);
			end
			if (cmd.move_wr) begin
				ccnt_q  <= ccnt_q - CW'(1);
				total_q <= total_q - TW'(1);
			end
			if (cmd.clear_all) begin
				claimed_q <= '0;
				total_q   <= '0;
				ccnt_q    <= '0;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status       <= cmd.code;
			found_entity <= cmd.emit_ent ? ent_rd : inv_ent;
			cell_count   <= 4'(ccnt_q);
			total_count  <= 12'(total_q);
			last         <= !cmd.emit_ent || sts.qry_last;
		end
	end

	always_comb begin
		sts.req_type     = type_q;
		sts.ent_inv      = (ent_q == inv_ent);
		sts.hash_last    = (cnt_q[2:0] == 3'd7);
		sts.mod_last     = (cnt_q == 5'd2);
		sts.slot_claimed = claimed_q[pos_q];
		sts.slot_match   = (slot_rd[SLW-1 -: 32] == x_q) && (slot_rd[CW +: 32] == y_q);
		sts.prb_last     = (n_q == POS_MAX);
		sts.found        = found_q;
		sts.cnt_full     = (ccnt_q >= PC_C);
		sts.cnt_zero     = (ccnt_q == '0);
		sts.scan_hit     = (ent_rd == ent_q);
		sts.scan_last    = ((i_q + CW'(1)) == ccnt_q);
		sts.qry_last     = ((8'(i_q) + 8'd1) == lim_eff);
		sts.out_busy     = out_valid;
	end

endmodule

[sv/grid_cell_hash_index_top.sv]
// ----------------------------------------------------------------------------
// grid_cell_hash_index_top
// Hash index from grid cells (x, y) to up to PER_CELL entity ids each.
// ----------------------------------------------------------------------------
// Use: one request word on the in channel (req_type, cell, ent_id,
// result_limit); result words leave on the out channel, last marks the
// final word of a request. Clear and non-query requests give one word,
// a query one per returned entity or one if none; types 5 to 7 give none.
// invalid_entity sits at APB byte address 0; write it only while idle.
// Requests are taken one at a time; in_ready is high only between them.
// Steps: FNV-1a one byte per cycle through the shift-add prime
// multiply, then the slot index (reciprocal multiply, back-multiply,
// final correction), then a read and a check per probed slot and a
// dispatch step, where refusals and misses leave. An add then writes
// and emits; remove or has-entity read and check each scanned entity,
// and on a hit remove moves the last entity into the gap; a query reads
// and emits per returned entity, and clear clears and emits.
// in_ready returns the cycle after the last word is loaded.
// Reset empties the index at once (claimed bits are flip-flops) and sets
// invalid_entity to all ones. A stalled out channel holds the word in the
// output register; the sequencer waits until it is taken.
// ----------------------------------------------------------------------------
`include "grid_cell_hash_index_top_defines.svh"

module grid_cell_hash_index_top import gchi_pkg::*; #(
	parameter int TABLE_SLOTS = 256,
	parameter int PER_CELL    = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] cell_x,
	input  logic signed [31:0] cell_y,
	input  logic [31:0]        ent_id,
	input  logic [3:0]         result_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [31:0]        found_entity,
	output logic [3:0]         cell_count,
	output logic [11:0]        total_count,
	output logic               last
);

	logic [31:0] inv_q;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			inv_q <= pwdata;
		end
	end

	gchi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gchi_dp #(.TABLE_SLOTS(TABLE_SLOTS), .PER_CELL(PER_CELL)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.inv_ent      (inv_q),
		.req_type     (req_type),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.ent_id       (ent_id),
		.result_limit (result_limit),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_entity (found_entity),
		.cell_count   (cell_count),
		.total_count  (total_count),
		.last         (last)
	);

	// a real request keeps the sequencer busy for the following cycle
	`GCHI_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready && req_type <= REQ_CLEAR, !in_ready)
	// only query words with status ok can be non-final
	`GCHI_ASSERT_NOW(a_err_is_last, out_valid && status != ST_OK, last)
	// a new word is never loaded over one that is still waiting
	`GCHI_ASSERT_NOW(a_no_overrun, cmd.emit, !out_valid)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: grid cell hash index
// Drives add/remove/query/has/clear requests over valid/ready, keeps a
// behavioral copy of the slot table and checks every result word in order.
// invalid_entity is rewritten over the APB port between phases while idle.
// ----------------------------------------------------------------------------
module testbench import gchi_pkg::*; ();

	localparam int SLOTS = 256;
	localparam int PER = 8;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_entity;
		logic [3:0]  cell_count;
		logic [11:0] total_count;
		logic        last;
	} result_t;

	// behavioral index model plus queue of expected result words
	class index_scoreboard;
		bit          claimed[SLOTS];
		logic [31:0] sx[SLOTS];
		logic [31:0] sy[SLOTS];
		int          cnt[SLOTS];
		logic [31:0] ents[SLOTS][PER];
		int          total;
		logic [31:0] inv;
		result_t     pending[$];
		int          errors;
		int          words;

		function new();
			inv = 32'hffff_ffff;
			total = 0;
			errors = 0;
			words = 0;
		endfunction

		function logic [31:0] fnv_fold(logic [31:0] x, logic [31:0] y);
			logic [63:0] k;
			logic [63:0] h;
			k = {x, y};
			h = 64'hcbf29ce484222325;
			for (int b = 0; b < 8; b++) begin
				h = h ^ ((k >> (b * 8)) & 64'hff);
				h = h * 64'd1099511628211;
			end
			return h[31:0] ^ h[63:32];
		endfunction

		function int find_slot(logic [31:0] x, logic [31:0] y, bit make);
			int pos;
			pos = fnv_fold(x, y) % SLOTS;
			for (int n = 0; n < SLOTS; n++) begin
				if (!claimed[pos]) begin
					if (!make)
						return -1;
					claimed[pos] = 1;
					sx[pos] = x;
					sy[pos] = y;
					cnt[pos] = 0;
					return pos;
				end
				if (sx[pos] == x && sy[pos] == y)
					return pos;
				pos = (pos + 1) % SLOTS;
			end
			return -1;
		endfunction

		function void push(logic [2:0] st, logic [31:0] e, int c, bit l);
			result_t r;
			r.status = st;
			r.found_entity = e;
			r.cell_count = c[3:0];
			r.total_count = total[11:0];
			r.last = l;
			pending.push_back(r);
		endfunction

		function void note_request(logic [2:0] t, logic [31:0] x, logic [31:0] y,
			logic [31:0] e, logic [3:0] lim);
			int s;
			int c;
			int n;
			bit hit;
			case (t)
				REQ_ADD: begin
					if (e == inv) begin
						s = find_slot(x, y, 0);
						push(ST_INVALID, inv, s < 0 ? 0 : cnt[s], 1);
					end else begin
						s = find_slot(x, y, 1);
						if (s < 0)
							push(ST_TABLE_FULL, inv, 0, 1);
						else if (cnt[s] >= PER)
							push(ST_CELL_FULL, inv, cnt[s], 1);
						else begin
							ents[s][cnt[s]] = e;
							cnt[s]++;
							total++;
							push(ST_OK, inv, cnt[s], 1);
						end
					end
				end
				REQ_REMOVE, REQ_HAS: begin
					s = find_slot(x, y, 0);
					c = s < 0 ? 0 : cnt[s];
					hit = 0;
					if (e == inv)
						push(ST_INVALID, inv, c, 1);
					else begin
						for (int i = 0; i < c && !hit; i++) begin
							if (ents[s][i] == e) begin
								hit = 1;
								if (t == REQ_REMOVE) begin
									ents[s][i] = ents[s][c - 1];
									c--;
									cnt[s] = c;
									total--;
								end
							end
						end
						push(hit ? ST_OK : ST_NOT_FOUND, inv, c, 1);
					end
				end
				REQ_QUERY: begin
					s = find_slot(x, y, 0);
					c = s < 0 ? 0 : cnt[s];
					if (c == 0)
						push(ST_NOT_FOUND, inv, 0, 1);
					else begin
						n = lim == 0 ? 1 : (lim > 8 ? 8 : lim);
						if (n > c)
							n = c;
						for (int i = 0; i < n; i++)
							push(ST_OK, ents[s][i], c, i + 1 == n);
					end
				end
				REQ_CLEAR: begin
					for (int i = 0; i < SLOTS; i++) begin
						claimed[i] = 0;
						cnt[i] = 0;
					end
					total = 0;
					push(ST_OK, inv, 0, 1);
				end
				default: ;
			endcase
		endfunction

		function void check_word(result_t got);
			result_t want;
			words++;
			if (pending.size() == 0) begin
				$error("unexpected result word status=%0d", got.status);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status != want.status) begin
				$error("status exp %0d got %0d", want.status, got.status);
				errors++;
			end
			if (got.found_entity != want.found_entity) begin
				$error("found_entity exp %h got %h", want.found_entity, got.found_entity);
				errors++;
			end
			if (got.cell_count != want.cell_count) begin
				$error("cell_count exp %0d got %0d", want.cell_count, got.cell_count);
				errors++;
			end
			if (got.total_count != want.total_count) begin
				$error("total_count exp %0d got %0d", want.total_count, got.total_count);
				errors++;
			end
			if (got.last != want.last) begin
				$error("last exp %0d got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         req_type;
	logic signed [31:0] cell_x;
	logic signed [31:0] cell_y;
	logic [31:0]        ent_id;
	logic [3:0]         result_limit;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic [31:0]        found_entity;
	logic [3:0]         cell_count;
	logic [11:0]        total_count;
	logic               last;

	index_scoreboard sb;
	int  cycles;
	bit  out_hold;
	bit  sending_done;
	int  reqs_sent;
	logic [31:0] pool_x[8];
	logic [31:0] pool_y[8];
	logic [31:0] pool_e[12];

	grid_cell_hash_index_top i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// result side: random stalls, check on every accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (out_valid && out_ready)
				sb.check_word('{status, found_entity, cell_count, total_count, last});
			if (out_hold)
				out_ready <= ($urandom_range(0, 9) < 7);
			else
				out_ready <= (gap_len() == 0);
		end
	end

	always @(posedge clk)
		if ($urandom_range(0, 199) == 0)
			out_hold <= ~out_hold;

	always @(posedge clk) begin
		if (cycles > 1500000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// valid stays high across back-to-back words; dropped only for a gap
	task automatic send_req(logic [2:0] t, logic [31:0] x, logic [31:0] y,
		logic [31:0] e, logic [3:0] lim);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		cell_x <= x;
		cell_y <= y;
		ent_id <= e;
		result_limit <= lim;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(t, x, y, e, lim);
		reqs_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_invalid(logic [31:0] v);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.inv = v;
	endtask

	task automatic random_phase(int n);
		int r;
		logic [2:0] t;
		logic [31:0] e;
		int k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 7);
			e = ($urandom_range(0, 19) == 0) ? sb.inv : pool_e[$urandom_range(0, 11)];
			if (r < 40)
				t = REQ_ADD;
			else if (r < 55)
				t = REQ_REMOVE;
			else if (r < 75)
				t = REQ_QUERY;
			else if (r < 90)
				t = REQ_HAS;
			else if (r < 92)
				t = REQ_CLEAR;
			else if (r < 95)
				t = 3'($urandom_range(5, 7));
			else
				t = REQ_ADD;
			if (r >= 95)
				send_req(t, $urandom, $urandom, $urandom, 4'($urandom));
			else
				send_req(t, pool_x[k], pool_y[k], e, 4'($urandom));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = '0;
		cell_x = '0;
		cell_y = '0;
		ent_id = '0;
		result_limit = '0;
		out_ready = 1'b0;
		out_hold = 1'b0;
		cycles = 0;
		reqs_sent = 0;
		sb = new();
		for (int i = 0; i < 8; i++) begin
			pool_x[i] = (i < 2) ? (i == 0 ? 32'h8000_0000 : 32'h7fff_ffff) : $urandom;
			pool_y[i] = (i < 2) ? (i == 0 ? 32'h7fff_ffff : 32'h8000_0000) : $urandom;
		end
		for (int i = 0; i < 12; i++)
			pool_e[i] = $urandom;
		pool_e[0] = 32'h0;
		pool_e[1] = 32'hffff_fffe;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: queries on empty, invalid id, fill a cell past full, limits, has/remove, bad type, clear
		send_req(REQ_QUERY, 32'h0, 32'h0, 32'h1, 4'd1);
		send_req(REQ_ADD, 32'h0, 32'h0, 32'hffff_ffff, 4'd0);
		for (int i = 0; i < 9; i++)
			send_req(REQ_ADD, pool_x[0], pool_y[0], 32'h100 + i, 4'd0);
		send_req(REQ_QUERY, pool_x[0], pool_y[0], 32'h0, 4'd0);
		send_req(REQ_QUERY, pool_x[0], pool_y[0], 32'h0, 4'd15);
		send_req(REQ_QUERY, pool_x[0], pool_y[0], 32'h0, 4'd3);
		send_req(REQ_HAS, pool_x[0], pool_y[0], 32'h103, 4'd0);
		send_req(REQ_HAS, pool_x[0], pool_y[0], 32'hffff_ffff, 4'd0);
		send_req(REQ_REMOVE, pool_x[0], pool_y[0], 32'h102, 4'd0);
		send_req(REQ_REMOVE, pool_x[0], pool_y[0], 32'h102, 4'd0);
		send_req(REQ_REMOVE, pool_x[1], pool_y[1], 32'h5, 4'd0);
		send_req(REQ_QUERY, pool_x[0], pool_y[0], 32'h0, 4'd8);
		send_req(3'd7, 32'h0, 32'h0, 32'h0, 4'd0);
		send_req(REQ_CLEAR, 32'h0, 32'h0, 32'h0, 4'd0);
		send_req(REQ_QUERY, pool_x[0], pool_y[0], 32'h0, 4'd8);

		random_phase(50);
		write_invalid(32'h0);
		random_phase(40);
		write_invalid(pool_e[3]);
		random_phase(30);
		write_invalid(32'hffff_ffff);
		random_phase(30);

		wait_idle();
		$display("Ran %0d requests, %0d result words checked, 3 invalid_entity settings.",
			reqs_sent, sb.words);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
